/* sv/scst_pkg.sv */
// Shared types, codes and the block-word decode for the shadow call stack tracker.
package scst_pkg;

    localparam int ADDR_W  = 32;
    localparam int ANNOT_W = 24;
    localparam int CODE_W  = 3;
    localparam int DEPTH_OUT_W = 7;

    // Input operations.
    localparam logic [1:0] OP_CALL     = 2'd0;
    localparam logic [1:0] OP_SP_WRITE = 2'd1;
    localparam logic [1:0] OP_BLOCK    = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    // Result codes.
    localparam logic [CODE_W-1:0] RES_PUSH      = 3'd0;
    localparam logic [CODE_W-1:0] RES_POP       = 3'd1;
    localparam logic [CODE_W-1:0] RES_RESIZE    = 3'd2;
    localparam logic [CODE_W-1:0] RES_ENTER     = 3'd3;
    localparam logic [CODE_W-1:0] RES_BAD_CALL  = 3'd4;
    localparam logic [CODE_W-1:0] RES_UNDERFLOW = 3'd5;
    localparam logic [CODE_W-1:0] RES_OVERFLOW  = 3'd6;

    localparam logic [ADDR_W-1:0] BASE_SPAN   = 32'd8;
    localparam logic [ADDR_W-1:0] BASE_SERIAL = 32'd1;
    localparam logic [ADDR_W-1:0] FIRST_PUSH_SERIAL = 32'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  serial;
        logic [ADDR_W-1:0]  caller;
        logic [ADDR_W-1:0]  func;
        logic [ADDR_W-1:0]  top;
        logic [ADDR_W-1:0]  bottom;
        logic [ANNOT_W-1:0] annot;
    } frame_t;

    typedef struct packed {
        logic [CODE_W-1:0]      code;
        frame_t                 frame;
        logic [DEPTH_OUT_W-1:0] depth;
    } result_t;

    // Low byte and high half-word of the custom instruction form the descriptor.
    function automatic logic [ANNOT_W-1:0] decode_block(input logic [31:0] word);
        decode_block = {word[31:16], word[7:0]};
    endfunction

endpackage

/* sv/shadow_call_stack_tracker_core.sv */
// Shadow call stack tracker: a small sequencer around one frame memory and one shared comparator.
// An item is taken in the idle state, in which the top frame is read from the frame memory, and is
// resolved in the evaluate state, where a call, a resize or a block annotation finishes. An unwinding
// write passes through that state again per frame popped (each pop reads the next frame down through
// the single read port), and an unwinding write that pops and then ends in a resize or an underflow
// hands over its final beat from the flush state. Op 3 is taken and gives nothing. Stall on the
// result channel holds the evaluate and flush states. The base frame lives in flip-flops and is
// rebuilt from the initial stack pointer register on reset or on a configuration write, so the block
// needs no clearing pass and is ready straight after reset.
module shadow_call_stack_tracker_core
    import scst_pkg::*;
#(
    parameter int MAX_FRAMES = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ADDR_W-1:0]      init_sp,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [1:0]             op,
    input  logic [ADDR_W-1:0]      stack_ptr,
    input  logic [ADDR_W-1:0]      caller_pc,
    input  logic [ADDR_W-1:0]      target_addr,
    input  logic [31:0]            block_word,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [CODE_W-1:0]      event_res,
    output logic [ADDR_W-1:0]      frame_id,
    output logic [ADDR_W-1:0]      frame_call_site,
    output logic [ADDR_W-1:0]      frame_function,
    output logic [ADDR_W-1:0]      frame_top,
    output logic [ADDR_W-1:0]      frame_bottom,
    output logic [DEPTH_OUT_W-1:0] stack_depth,
    output logic [11:0]            block_index,
    output logic [7:0]             loop_number,
    output logic [2:0]             loop_level,
    output logic                   loop_header,
    output logic                   last
);

    localparam int IDX_W   = $clog2(MAX_FRAMES);
    localparam int DEPTH_W = $clog2(MAX_FRAMES + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE  = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_TWO  = DEPTH_W'(2);
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(MAX_FRAMES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [1:0]         op_reg;
    logic [ADDR_W-1:0]  sp_reg, site_reg, target_reg;
    logic [ANNOT_W-1:0] annot_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [ADDR_W-1:0]  serial_reg, serial_next;
    result_t            hold_reg, hold_next;
    logic               hold_valid_reg, hold_valid_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;

    logic               accept, cfg_wr, out_free;
    logic               rd_en, wr_en;
    logic [IDX_W-1:0]   rd_idx, wr_idx;
    frame_t             cur_frame, wr_frame;
    logic [ADDR_W-1:0]  cmp_b;
    logic               sp_ge;
    logic               have_res, is_final;
    result_t            res;

    assign cfg_ready  = (state_reg == S_IDLE);
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign item_stall = (state_reg != S_IDLE) || cfg_valid;
    assign accept     = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;

    scst_frame_store #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_value (init_sp),
        .rd_en     (rd_en),
        .rd_idx    (rd_idx),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_frame  (wr_frame),
        .rd_frame  (cur_frame)
    );

    // The one comparator: bottom bound for a call, top bound for unwinding.
    assign cmp_b = (op_reg == OP_CALL) ? cur_frame.bottom : cur_frame.top;
    assign sp_ge = (sp_reg >= cmp_b);

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        serial_next     = serial_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && result_stall;
        rd_en           = 1'b0;
        rd_idx          = IDX_W'(depth_reg - DEPTH_ONE);
        wr_en           = 1'b0;
        wr_idx          = IDX_W'(depth_reg - DEPTH_ONE);
        wr_frame        = cur_frame;
        have_res        = 1'b0;
        is_final        = 1'b1;
        res.code        = RES_PUSH;
        res.frame       = cur_frame;
        res.depth       = DEPTH_OUT_W'(depth_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_en = 1'b1;
                    if (op != OP_NONE)
                    begin
                        state_next = S_EVAL;
                    end
                end
            end

            S_EVAL:
            begin
                if (out_free)
                begin
                    case (op_reg)
                        OP_CALL:
                        begin
                            have_res = 1'b1;
                            if (sp_ge)
                            begin
                                res.code = RES_BAD_CALL;
                            end
                            else if (depth_reg == DEPTH_FULL)
                            begin
                                res.code = RES_OVERFLOW;
                            end
                            else
                            begin
                                wr_frame.serial = serial_reg;
                                wr_frame.caller = site_reg;
                                wr_frame.func   = target_reg;
                                wr_frame.top    = cur_frame.bottom;
                                wr_frame.bottom = sp_reg;
                                wr_frame.annot  = '0;
                                wr_en           = 1'b1;
                                wr_idx          = IDX_W'(depth_reg);
                                depth_next      = depth_reg + DEPTH_ONE;
                                serial_next     = serial_reg + 32'd1;
                                res.code        = RES_PUSH;
                                res.frame       = wr_frame;
                                res.depth       = DEPTH_OUT_W'(depth_reg + DEPTH_ONE);
                            end
                        end
                        OP_SP_WRITE:
                        begin
                            if (sp_ge)
                            begin
                                have_res = 1'b1;
                                if (depth_reg == DEPTH_ONE)
                                begin
                                    res.code = RES_UNDERFLOW;
                                end
                                else
                                begin
                                    // Pop, and read the frame below for the next evaluation.
                                    is_final   = 1'b0;
                                    depth_next = depth_reg - DEPTH_ONE;
                                    rd_en      = 1'b1;
                                    rd_idx     = IDX_W'(depth_reg - DEPTH_TWO);
                                    res.code   = RES_POP;
                                    res.depth  = DEPTH_OUT_W'(depth_reg - DEPTH_ONE);
                                end
                            end
                            else if (cur_frame.bottom != sp_reg)
                            begin
                                have_res        = 1'b1;
                                wr_frame.bottom = sp_reg;
                                wr_en           = 1'b1;
                                res.code        = RES_RESIZE;
                                res.frame       = wr_frame;
                            end
                        end
                        OP_BLOCK:
                        begin
                            have_res       = 1'b1;
                            wr_frame.annot = annot_reg;
                            wr_en          = 1'b1;
                            res.code       = RES_ENTER;
                            res.frame      = wr_frame;
                        end
                        default:
                        begin
                            have_res = 1'b0;
                        end
                    endcase

                    // The newest result waits in the hold stage until it is known whether
                    // another one follows it.
                    if (have_res && !is_final)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_next       = hold_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        hold_next       = res;
                        hold_valid_next = 1'b1;
                    end
                    else if (have_res)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_next       = hold_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                            hold_next      = res;
                            state_next     = S_FLUSH;
                        end
                        else
                        begin
                            out_next       = res;
                            out_last_next  = 1'b1;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        if (hold_valid_reg)
                        begin
                            out_next        = hold_reg;
                            out_last_next   = 1'b1;
                            out_valid_next  = 1'b1;
                            hold_valid_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            depth_next  = DEPTH_ONE;
            serial_next = FIRST_PUSH_SERIAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            depth_reg      <= DEPTH_ONE;
            serial_reg     <= FIRST_PUSH_SERIAL;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            serial_reg     <= serial_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            sp_reg     <= stack_ptr;
            site_reg   <= caller_pc;
            target_reg <= target_addr;
            annot_reg  <= decode_block(block_word);
        end
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign result_valid    = out_valid_reg;
    assign event_res       = out_reg.code;
    assign frame_id        = out_reg.frame.serial;
    assign frame_call_site = out_reg.frame.caller;
    assign frame_function  = out_reg.frame.func;
    assign frame_top       = out_reg.frame.top;
    assign frame_bottom    = out_reg.frame.bottom;
    assign stack_depth     = out_reg.depth;
    assign block_index     = out_reg.frame.annot[11:0];
    assign loop_number     = out_reg.frame.annot[19:12];
    assign loop_level      = out_reg.frame.annot[22:20];
    assign loop_header     = out_reg.frame.annot[23];
    assign last            = out_last_reg;

endmodule

/* sv/scst_frame_store.sv */
// Frame memory with the base frame held in flip-flops and a registered read port.
module scst_frame_store
    import scst_pkg::*;
#(
    parameter int MAX_FRAMES = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr,
    input  logic [ADDR_W-1:0]                 cfg_value,
    input  logic                              rd_en,
    input  logic [$clog2(MAX_FRAMES)-1:0]     rd_idx,
    input  logic                              wr_en,
    input  logic [$clog2(MAX_FRAMES)-1:0]     wr_idx,
    input  frame_t                            wr_frame,
    output frame_t                            rd_frame
);

    localparam int IDX_W = $clog2(MAX_FRAMES);

    frame_t             mem [MAX_FRAMES];
    frame_t             rd_data_reg;
    logic               rd_base_reg;
    logic [ADDR_W-1:0]  init_sp_reg;
    logic [ADDR_W-1:0]  base_bottom_reg;
    logic [ANNOT_W-1:0] base_annot_reg;
    frame_t             base_frame;

    // Entry 0 never lives in the memory, so the memory needs no clearing.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx != IDX_W'(0)))
        begin
            mem[wr_idx] <= wr_frame;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_base_reg     <= 1'b1;
            init_sp_reg     <= '0;
            base_bottom_reg <= '0;
            base_annot_reg  <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_base_reg <= (rd_idx == IDX_W'(0));
            end
            if (cfg_wr)
            begin
                init_sp_reg     <= cfg_value;
                base_bottom_reg <= cfg_value;
                base_annot_reg  <= '0;
            end
            else if (wr_en && (wr_idx == IDX_W'(0)))
            begin
                base_bottom_reg <= wr_frame.bottom;
                base_annot_reg  <= wr_frame.annot;
            end
        end
    end

    always_comb
    begin
        base_frame.serial = BASE_SERIAL;
        base_frame.caller = '0;
        base_frame.func   = '0;
        base_frame.top    = init_sp_reg + BASE_SPAN;
        base_frame.bottom = base_bottom_reg;
        base_frame.annot  = base_annot_reg;
    end

    assign rd_frame = rd_base_reg ? base_frame : rd_data_reg;

endmodule

/* sv/scst_checker.sv */
// Port-level checks for the shadow call stack tracker, bound to the top level.
module scst_checker
    import scst_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic                   item_valid,
    input logic                   item_stall,
    input logic [1:0]             op,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [CODE_W-1:0]      event_res,
    input logic [ADDR_W-1:0]      frame_id,
    input logic                   last
);

    // A held result beat stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(event_res) && $stable(frame_id) && $stable(last))
        else $error("stalled result beat changed");

    // A real operation keeps the block busy for at least the cycle after it is taken.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (op != OP_NONE) |=> item_stall)
        else $error("item taken while previous item still in progress");

    // These events always close their item.
    a_final_codes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_res == RES_PUSH || event_res == RES_ENTER ||
            event_res == RES_BAD_CALL || event_res == RES_OVERFLOW ||
            event_res == RES_UNDERFLOW) |-> last)
        else $error("final-only event without last");

    // Items are held off while busy and while a configuration beat is offered.
    a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid || !cfg_ready |-> item_stall)
        else $error("items open during configuration or while busy");

endmodule

bind shadow_call_stack_tracker_core scst_checker u_scst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .event_res    (event_res),
    .frame_id     (frame_id),
    .last         (last)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the shadow call stack tracker: directed table, then random phases.
module tb_top;
    import scst_pkg::*;

    localparam int FRAMES      = 64;
    localparam int GAP_MAX     = 18;
    localparam int SETTLE      = 6;
    localparam int TAIL        = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 2000000;
    localparam int DIVE_LEN    = 70;

    typedef struct packed {
        logic [CODE_W-1:0]      code;
        logic [31:0]            id;
        logic [31:0]            site;
        logic [31:0]            func;
        logic [31:0]            top;
        logic [31:0]            bottom;
        logic [DEPTH_OUT_W-1:0] depth;
        logic [11:0]            blk;
        logic [7:0]             loop_no;
        logic [2:0]             level;
        logic                   header;
        logic                   last;
    } beat_t;

    typedef struct packed {
        bit                     cfg;
        bit                     typed;
        logic [1:0]             op;
        logic [31:0]            sp;
        logic [31:0]            site;
        logic [31:0]            tgt;
        logic [31:0]            word;
        logic [CODE_W-1:0]      code;
        logic [31:0]            id;
        logic [31:0]            top;
        logic [31:0]            bot;
        logic [DEPTH_OUT_W-1:0] depth;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [31:0]            top_value;
    logic                   item_valid;
    logic                   item_stall;
    logic [1:0]             op;
    logic [31:0]            stack_ptr;
    logic [31:0]            caller_pc;
    logic [31:0]            target_addr;
    logic [31:0]            block_word;
    logic                   result_valid;
    logic                   result_stall;
    logic [CODE_W-1:0]      event_res;
    logic [31:0]            frame_id;
    logic [31:0]            frame_call_site;
    logic [31:0]            frame_function;
    logic [31:0]            frame_top;
    logic [31:0]            frame_bottom;
    logic [DEPTH_OUT_W-1:0] stack_depth;
    logic [11:0]            block_index;
    logic [7:0]             loop_number;
    logic [2:0]             loop_level;
    logic                   loop_header;
    logic                   last;

    shadow_call_stack_tracker_core DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .init_sp         (top_value),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .op              (op),
        .stack_ptr       (stack_ptr),
        .caller_pc       (caller_pc),
        .target_addr     (target_addr),
        .block_word      (block_word),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .event_res       (event_res),
        .frame_id        (frame_id),
        .frame_call_site (frame_call_site),
        .frame_function  (frame_function),
        .frame_top       (frame_top),
        .frame_bottom    (frame_bottom),
        .stack_depth     (stack_depth),
        .block_index     (block_index),
        .loop_number     (loop_number),
        .loop_level      (loop_level),
        .loop_header     (loop_header),
        .last            (last)
    );

    // Shadow copy of the frame stack, kept in step with every accepted item.
    logic [31:0]            site_m [FRAMES];
    logic [31:0]            func_m [FRAMES];
    logic [31:0]            top_m [FRAMES];
    logic [31:0]            bot_m [FRAMES];
    logic [31:0]            id_m [FRAMES];
    logic [ANNOT_W-1:0]     annot_m [FRAMES];
    logic [DEPTH_OUT_W-1:0] depth_n;
    logic [31:0]            serial_n;

    beat_t fresh[$];
    beat_t due_beats[$];
    row_t  plan[$];

    int  cycles;
    int  mismatches;
    int  surplus;
    int  reports;
    int  beats_seen;
    int  items_sent;
    int  cfg_writes;
    int  deepest;
    int  per_code [8];
    int  send_quiet;
    int  dive_left;
    bit  unwind_next;
    bit  hold_request;
    bit  hold_taken;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still due", cycles, due_beats.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void rebuild_stack(input logic [31:0] sp0);
        for (int i = 0; i < FRAMES; i++)
        begin
            site_m[i]  = '0;
            func_m[i]  = '0;
            top_m[i]   = '0;
            bot_m[i]   = '0;
            id_m[i]    = '0;
            annot_m[i] = '0;
        end
        top_m[0] = sp0 + BASE_SPAN;
        bot_m[0] = sp0;
        id_m[0]  = BASE_SERIAL;
        depth_n  = 1;
        serial_n = FIRST_PUSH_SERIAL;
    endfunction

    function automatic beat_t snapshot_frame(input logic [CODE_W-1:0] code, input int idx);
        beat_t b;
        b.code    = code;
        b.id      = id_m[idx];
        b.site    = site_m[idx];
        b.func    = func_m[idx];
        b.top     = top_m[idx];
        b.bottom  = bot_m[idx];
        b.depth   = depth_n;
        b.blk     = annot_m[idx][11:0];
        b.loop_no = annot_m[idx][19:12];
        b.level   = annot_m[idx][22:20];
        b.header  = annot_m[idx][23];
        b.last    = 1'b0;
        return b;
    endfunction

    function automatic void add_beat(input beat_t b);
        fresh.insert(fresh.size(), b);
    endfunction

    function automatic void add_row(input row_t r);
        plan.insert(plan.size(), r);
    endfunction

    // Works out the beats one item causes and leaves them in fresh.
    function automatic void track_event(input logic [1:0] o, input logic [31:0] sp, site, tgt,
                                        input logic [31:0] word);
        int    t;
        int    f;
        bit    under;
        beat_t b;
        fresh.delete();
        t = depth_n - 1;
        case (o)
            OP_CALL:
            begin
                if (sp >= bot_m[t])
                    add_beat(snapshot_frame(RES_BAD_CALL, t));
                else if (depth_n >= FRAMES)
                    add_beat(snapshot_frame(RES_OVERFLOW, t));
                else
                begin
                    f = depth_n;
                    id_m[f]    = serial_n;
                    serial_n   = serial_n + 1;
                    site_m[f]  = site;
                    func_m[f]  = tgt;
                    top_m[f]   = bot_m[t];
                    bot_m[f]   = sp;
                    annot_m[f] = '0;
                    depth_n    = depth_n + 1;
                    add_beat(snapshot_frame(RES_PUSH, f));
                end
            end
            OP_SP_WRITE:
            begin
                under = 1'b0;
                while (!under && sp >= top_m[depth_n - 1])
                begin
                    if (depth_n <= 1)
                        under = 1'b1;
                    else
                    begin
                        depth_n = depth_n - 1;
                        add_beat(snapshot_frame(RES_POP, depth_n));
                    end
                end
                t = depth_n - 1;
                if (under)
                    add_beat(snapshot_frame(RES_UNDERFLOW, t));
                else if (bot_m[t] != sp)
                begin
                    bot_m[t] = sp;
                    add_beat(snapshot_frame(RES_RESIZE, t));
                end
            end
            OP_BLOCK:
            begin
                // Low byte and upper half-word of the word make up the descriptor.
                annot_m[t] = {word[31:16], word[7:0]};
                add_beat(snapshot_frame(RES_ENTER, t));
            end
            default:
            begin
            end
        endcase
        if (fresh.size() > 0)
        begin
            b = fresh[fresh.size() - 1];
            b.last = 1'b1;
            fresh[fresh.size() - 1] = b;
        end
    endfunction

    function automatic int draw_gap(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(24) == 0)
        begin
            quiet = $urandom_range(40, 10);
            return 0;
        end
        return $urandom_range(GAP_MAX);
    endfunction

    function automatic string show(input beat_t b);
        return {$sformatf("code=%0d id=%h site=%h fn=%h top=%h bot=%h depth=%0d ",
                          b.code, b.id, b.site, b.func, b.top, b.bottom, b.depth),
                $sformatf("blk=%h loop=%h lvl=%0d hdr=%b last=%b",
                          b.blk, b.loop_no, b.level, b.header, b.last)};
    endfunction

    function automatic row_t step_row(input logic [1:0] o, input logic [31:0] sp, site, tgt,
                                      input logic [31:0] word);
        row_t r;
        r      = '0;
        r.op   = o;
        r.sp   = sp;
        r.site = site;
        r.tgt  = tgt;
        r.word = word;
        return r;
    endfunction

    function automatic row_t seen(input row_t r, input logic [CODE_W-1:0] code,
                                  input logic [31:0] id, top, bot,
                                  input logic [DEPTH_OUT_W-1:0] depth);
        row_t q;
        q       = r;
        q.typed = 1'b1;
        q.code  = code;
        q.id    = id;
        q.top   = top;
        q.bot   = bot;
        q.depth = depth;
        return q;
    endfunction

    function automatic row_t cfg_row(input logic [31:0] v);
        row_t r;
        r     = '0;
        r.cfg = 1'b1;
        r.sp  = v;
        return r;
    endfunction

    // Offers one item, waits for it to be taken and then books its beats as due.
    task automatic offer_item(input logic [1:0] o, input logic [31:0] sp, site, tgt,
                              input logic [31:0] word);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        op          <= o;
        stack_ptr   <= sp;
        caller_pc   <= site;
        target_addr <= tgt;
        block_word  <= word;
        do
            @(posedge clk);
        while (item_stall);
        foreach (fresh[i])
            due_beats.insert(due_beats.size(), fresh[i]);
        items_sent++;
    endtask

    // The register is only written once the block has drained and settled.
    task automatic load_stack_top(input logic [31:0] v);
        item_valid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        top_value <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rebuild_stack(v);
        cfg_writes++;
    endtask

    // Draws a random item, mostly well-formed against the current shadow stack.
    task automatic random_item(output logic [1:0] o, output logic [31:0] sp, site, tgt,
                               output logic [31:0] word);
        int          pick;
        int          kind;
        int          idx;
        logic [31:0] bot;
        logic [31:0] top;
        logic [31:0] lo;
        bot  = bot_m[depth_n - 1];
        top  = top_m[depth_n - 1];
        sp   = $urandom;
        site = $urandom;
        tgt  = $urandom;
        word = $urandom;
        pick = $urandom_range(99);
        kind = $urandom_range(9);
        if (dive_left > 0)
        begin
            dive_left--;
            if (dive_left == 0)
                unwind_next = 1'b1;
            pick = 0;
            kind = 0;
        end
        else if (unwind_next)
        begin
            unwind_next = 1'b0;
            pick = -1;
        end

        if (pick < 0)
        begin
            // Unwinding to the first pushed frame's top clears the whole stack above the base.
            o  = OP_SP_WRITE;
            sp = top_m[1];
        end
        else if (pick < 40)
        begin
            o = OP_CALL;
            if (kind <= 6)
                sp = (bot > 64) ? bot - $urandom_range(64, 1)
                                : ((bot > 0) ? $urandom_range(bot - 1, 0) : $urandom);
            else if (kind == 7)
                sp = (bot > 0) ? $urandom_range(bot - 1, 0) : $urandom;
            else if (kind == 8)
                sp = $urandom_range(32'hFFFF_FFFF, bot);
        end
        else if (pick < 75)
        begin
            o = OP_SP_WRITE;
            if (kind <= 2)
            begin
                idx = $urandom_range(depth_n - 1, 0);
                sp  = top_m[idx] - $urandom_range(3, 0);
            end
            else if (kind <= 5)
            begin
                lo = (bot > 32) ? bot - 32 : 32'd0;
                sp = $urandom_range(top - 1, lo);
            end
            else if (kind == 6)
                sp = bot;
            else if (kind == 7)
                sp = $urandom_range(32'hFFFF_FFFF, top_m[0]);
        end
        else if (pick < 95)
            o = OP_BLOCK;
        else
            o = OP_NONE;
    endtask

    initial
    begin : stimulus
        row_t        r;
        beat_t       b;
        logic [1:0]  o;
        logic [31:0] sp;
        logic [31:0] site;
        logic [31:0] tgt;
        logic [31:0] word;
        logic [31:0] v;
        int          quota;
        int          n;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        top_value    = '0;
        item_valid   = 1'b0;
        op           = OP_NONE;
        stack_ptr    = '0;
        caller_pc    = '0;
        target_addr  = '0;
        block_word   = '0;
        hold_request = 1'b0;
        send_quiet   = 0;
        dive_left    = 0;
        unwind_next  = 1'b0;
        rebuild_stack(32'd0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the register at zero no call can be valid and the base frame spans 0 to 8.
        add_row(seen(step_row(OP_CALL, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0),
                     RES_BAD_CALL, 32'd1, 32'd8, 32'd0, 7'd1));
        add_row(seen(step_row(OP_CALL, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF),
                     RES_BAD_CALL, 32'd1, 32'd8, 32'd0, 7'd1));
        add_row(step_row(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF));
        add_row(seen(step_row(OP_BLOCK, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF),
                     RES_ENTER, 32'd1, 32'd8, 32'd0, 7'd1));
        add_row(seen(step_row(OP_BLOCK, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0),
                     RES_ENTER, 32'd1, 32'd8, 32'd0, 7'd1));
        add_row(seen(step_row(OP_SP_WRITE, 32'd8, 32'h0, 32'h0, 32'h0),
                     RES_UNDERFLOW, 32'd1, 32'd8, 32'd0, 7'd1));
        add_row(seen(step_row(OP_SP_WRITE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0),
                     RES_UNDERFLOW, 32'd1, 32'd8, 32'd0, 7'd1));
        add_row(step_row(OP_SP_WRITE, 32'd0, 32'h0, 32'h0, 32'h0));
        add_row(seen(step_row(OP_SP_WRITE, 32'd7, 32'h0, 32'h0, 32'h0),
                     RES_RESIZE, 32'd1, 32'd8, 32'd7, 7'd1));
        // Highest value without wrap: the base frame then reaches the very top of the address space.
        add_row(cfg_row(32'hFFFF_FFF7));
        add_row(seen(step_row(OP_CALL, 32'hFFFF_FFF0, 32'h0, 32'hFFFF_FFFF, 32'h0),
                     RES_PUSH, 32'd2, 32'hFFFF_FFF7, 32'hFFFF_FFF0, 7'd2));
        add_row(seen(step_row(OP_CALL, 32'hFFFF_FF00, 32'h1234_5678, 32'h9ABC_DEF0,
                              32'h0),
                     RES_PUSH, 32'd3, 32'hFFFF_FFF0, 32'hFFFF_FF00, 7'd3));
        add_row(seen(step_row(OP_CALL, 32'hFFFF_FF00, 32'h0, 32'h0, 32'h0),
                     RES_BAD_CALL, 32'd3, 32'hFFFF_FFF0, 32'hFFFF_FF00, 7'd3));
        add_row(step_row(OP_BLOCK, 32'h0, 32'h0, 32'h0, 32'h00A5_5A3C));
        add_row(seen(step_row(OP_SP_WRITE, 32'hFFFF_FF80, 32'h0, 32'h0, 32'h0),
                     RES_RESIZE, 32'd3, 32'hFFFF_FFF0, 32'hFFFF_FF80, 7'd3));
        add_row(step_row(OP_CALL, 32'hFFFF_FF40, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0));
        add_row(step_row(OP_CALL, 32'h0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0));
        add_row(step_row(OP_SP_WRITE, 32'hFFFF_FFF0, 32'h0, 32'h0, 32'h0));
        add_row(step_row(OP_BLOCK, 32'h0, 32'h0, 32'h0, 32'h80F0_00FF));
        add_row(step_row(OP_SP_WRITE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        add_row(cfg_row(32'h0000_1000));
        add_row(seen(step_row(OP_CALL, 32'h0000_0800, 32'h0000_4000, 32'h0000_8000,
                              32'h0),
                     RES_PUSH, 32'd2, 32'h0000_1000, 32'h0000_0800, 7'd2));
        add_row(step_row(OP_NONE, 32'h0, 32'h0, 32'h0, 32'h0));
        add_row(seen(step_row(OP_SP_WRITE, 32'h0000_0FFF, 32'h0, 32'h0, 32'h0),
                     RES_RESIZE, 32'd2, 32'h0000_1000, 32'h0000_0FFF, 7'd2));
        // Pops back to the base, whose bottom already matches, so no resize follows.
        add_row(step_row(OP_SP_WRITE, 32'h0000_1000, 32'h0, 32'h0, 32'h0));

        for (int i = 0; i < plan.size(); i++)
        begin
            r = plan[i];
            if (r.cfg)
                load_stack_top(r.sp);
            else
            begin
                track_event(r.op, r.sp, r.site, r.tgt, r.word);
                if (r.typed)
                begin
                    b        = fresh[0];
                    b.code   = r.code;
                    b.id     = r.id;
                    b.top    = r.top;
                    b.bottom = r.bot;
                    b.depth  = r.depth;
                    fresh[0] = b;
                end
                offer_item(r.op, r.sp, r.site, r.tgt, r.word);
            end
        end

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       begin v = $urandom_range(32'hFFFF_0000, 32'h0001_0000); quota = 70; end
                1:       begin v = 32'd0;                                       quota = 20; end
                2:       begin v = 32'hFFFF_FFF7;                               quota = 80; end
                3:       begin v = $urandom_range(32'hFFFF_FFF7, 32'd0);        quota = 60; end
                default: begin v = $urandom_range(32'h0000_1000, 32'h0000_0040); quota = 50; end
            endcase
            load_stack_top(v);
            n = 0;
            while (n < quota)
            begin
                if (p == 0 && n == 10)
                    hold_request = 1'b1;
                // A long run of calls fills the stack to overflow, then one write empties it.
                if ((p == 0 || p == 2) && n == 5)
                    dive_left = DIVE_LEN;
                random_item(o, sp, site, tgt, word);
                track_event(o, sp, site, tgt, word);
                offer_item(o, sp, site, tgt, word);
                if (o != OP_NONE)
                    n++;
            end
        end

        item_valid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        $display("ran %0d items under %0d base pointer loads; %0d result beats, deepest stack %0d",
                 items_sent, cfg_writes, beats_seen, deepest);
        $display("push %0d pop %0d resize %0d enter %0d bad call %0d underflow %0d overflow %0d",
                 per_code[RES_PUSH], per_code[RES_POP], per_code[RES_RESIZE],
                 per_code[RES_ENTER], per_code[RES_BAD_CALL], per_code[RES_UNDERFLOW],
                 per_code[RES_OVERFLOW]);
        if (mismatches == 0 && surplus == 0 && due_beats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : result_side
        int    quiet;
        int    left;
        beat_t got;
        beat_t want;
        result_stall = 1'b0;
        hold_taken   = 1'b0;
        quiet        = 0;
        left         = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                got = {event_res, frame_id, frame_call_site, frame_function, frame_top,
                       frame_bottom, stack_depth, block_index, loop_number, loop_level,
                       loop_header, last};
                beats_seen++;
                per_code[got.code]++;
                if (got.depth > deepest)
                    deepest = got.depth;
                if (due_beats.size() == 0)
                begin
                    surplus++;
                    reports++;
                    if (reports <= 10)
                        $display("beat with nothing due at %0t: %s", $realtime, show(got));
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        reports++;
                        if (reports <= 10)
                        begin
                            $display("mismatch at %0t, expected %s", $realtime, show(want));
                            $display("                   got      %s", show(got));
                        end
                    end
                end
                left = draw_gap(quiet);
            end
            // One long hold while the sender keeps offering, so the block backs up to its input.
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                left       = HOLD_CYCLES;
            end
            if (left > 0)
            begin
                result_stall <= 1'b1;
                left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

endmodule

/* shadow_call_stack_tracker_core.f */
sv/scst_pkg.sv
sv/scst_frame_store.sv
sv/shadow_call_stack_tracker_core.sv
sv/scst_checker.sv
bench/tb_top.sv
